FILE: rtl/kwm_pkg.sv
// Shared constants, codes and types of the k-way sorted merge core.
package kwm_pkg;

    localparam int LANES      = 8;
    localparam int LANE_DEPTH = 256;

    localparam int LANE_W    = $clog2(LANES);
    localparam int TREE_N    = 1 << LANE_W;
    localparam int SLOT_W    = $clog2(LANE_DEPTH);
    localparam int CNT_W     = $clog2(LANE_DEPTH + 1);
    localparam int MEM_DEPTH = LANES * LANE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam int CMD_W     = 2;
    localparam int IN_LANE_W = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int DATA_W    = 40;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

    // Classified operations handed from front to back
    typedef logic [2:0] op_t;
    localparam op_t OP_NOP   = 3'd0;
    localparam op_t OP_LOAD  = 3'd1;
    localparam op_t OP_DROP  = 3'd2;
    localparam op_t OP_POP   = 3'd3;
    localparam op_t OP_CLEAR = 3'd4;

    typedef struct packed {
        op_t                       op;
        logic [LANE_W-1:0]         lane;
        logic signed [VALUE_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value;
        logic [IN_LANE_W-1:0]      lane;
    } result_t;

endpackage

FILE: rtl/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/kwm_front.sv
// Input side: accept transfers, classify commands, buffer them in a short queue.
module kwm_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [kwm_pkg::DATA_W-1:0]   s_tdata,
    input  logic [kwm_pkg::CMD_W-1:0]    s_tuser,
    output logic                         deq_valid,
    input  logic                         deq_ready,
    output kwm_pkg::cmd_item_t           deq_item
);
    import kwm_pkg::*;

    cmd_item_t          q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  fill_reg, fill_next;
    logic               push, pop;
    logic [IN_LANE_W-1:0] lane_in;
    logic               lane_ok;
    cmd_item_t          item_in;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign lane_in = s_tdata[IN_LANE_W-1:0];
    assign lane_ok = {{(32-IN_LANE_W){1'b0}}, lane_in} < 32'(LANES);

    always_comb begin
        item_in.lane  = LANE_W'(lane_in);
        item_in.value = s_tdata[IN_LANE_W +: VALUE_W];
        unique case (s_tuser)
            CMD_LOAD:  item_in.op = lane_ok ? OP_LOAD : OP_DROP;
            CMD_POP:   item_in.op = OP_POP;
            CMD_CLEAR: item_in.op = OP_CLEAR;
            default:   item_in.op = OP_NOP;
        endcase
    end

    assign s_tready  = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign deq_valid = (fill_reg != '0);
    assign deq_item  = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = deq_valid && deq_ready;

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end
endmodule

FILE: rtl/kwm_back.sv
// Execution side: lane queues, head registers, minimum search and result register.
module kwm_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 deq_valid,
    output logic                 deq_ready,
    input  kwm_pkg::cmd_item_t   deq_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output kwm_pkg::result_t     res
);
    import kwm_pkg::*;

    localparam logic S_EXEC   = 1'b0;
    localparam logic S_REFILL = 1'b1;

    logic                      state_reg, state_next;
    logic [CNT_W-1:0]          count_reg   [LANES];
    logic [SLOT_W-1:0]         wr_slot_reg [LANES];
    logic [SLOT_W-1:0]         rd_slot_reg [LANES];
    logic signed [VALUE_W-1:0] head_value_reg [LANES];
    logic [LANES-1:0]          head_valid_reg;
    logic [LANE_W-1:0]         refill_lane_reg;
    logic                      res_valid_reg, res_valid_next;
    result_t                   res_reg, res_next;

    // Minimum tree, heap numbered, leaves at TREE_N + lane
    logic                      nd_ok  [2*TREE_N];
    logic signed [VALUE_W-1:0] nd_val [2*TREE_N];
    logic [LANE_W-1:0]         nd_idx [2*TREE_N];

    logic                      take, any_valid, full, pop_last;
    logic                      do_load, do_pop, do_clear;
    logic [LANE_W-1:0]         win_lane, sel_lane;
    logic signed [VALUE_W-1:0] win_value;
    logic [CNT_W-1:0]          sel_count;
    logic [SLOT_W-1:0]         sel_wr, sel_rd;
    logic [ADDR_W-1:0]         waddr, raddr;
    logic [VALUE_W-1:0]        rdata;
    logic [LANES-1:0]          cnt_nz;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == SLOT_W'(LANE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [LANE_W-1:0] l,
                                                   input logic [SLOT_W-1:0] s);
        mem_addr = ADDR_W'(l) * ADDR_W'(LANE_DEPTH) + ADDR_W'(s);
    endfunction

    always_comb begin
        for (int i = 0; i < TREE_N; i++) begin
            nd_ok[TREE_N + i]  = (i < LANES) ? head_valid_reg[i] : 1'b0;
            nd_val[TREE_N + i] = (i < LANES) ? head_value_reg[i] : '0;
            nd_idx[TREE_N + i] = LANE_W'(i);
        end
        nd_ok[0]  = 1'b0;
        nd_val[0] = '0;
        nd_idx[0] = '0;
        // Left subtree holds lower lanes, so it wins ties
        for (int n = TREE_N - 1; n >= 1; n--) begin
            if (nd_ok[2*n] && (!nd_ok[2*n+1] || nd_val[2*n] <= nd_val[2*n+1])) begin
                nd_ok[n]  = nd_ok[2*n];
                nd_val[n] = nd_val[2*n];
                nd_idx[n] = nd_idx[2*n];
            end else begin
                nd_ok[n]  = nd_ok[2*n+1];
                nd_val[n] = nd_val[2*n+1];
                nd_idx[n] = nd_idx[2*n+1];
            end
        end
    end

    assign any_valid = nd_ok[1];
    assign win_lane  = nd_idx[1];
    assign win_value = nd_val[1];

    assign take      = (state_reg == S_EXEC) && deq_valid && (!res_valid_reg || res_ready);
    assign deq_ready = take;

    assign sel_lane  = (deq_item.op == OP_POP) ? win_lane : deq_item.lane;
    assign sel_count = count_reg[sel_lane];
    assign sel_wr    = wr_slot_reg[sel_lane];
    assign sel_rd    = rd_slot_reg[sel_lane];
    assign full      = (sel_count == CNT_W'(LANE_DEPTH));
    assign pop_last  = (sel_count == CNT_W'(1));

    assign do_load   = take && (deq_item.op == OP_LOAD) && !full;
    assign do_pop    = take && (deq_item.op == OP_POP) && any_valid;
    assign do_clear  = take && (deq_item.op == OP_CLEAR);

    assign waddr = mem_addr(sel_lane, sel_wr);
    assign raddr = mem_addr(sel_lane, slot_inc(sel_rd));

    kwm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MEM_DEPTH)
    ) u_lane_ram (
        .clk   (aclk),
        .we    (do_load),
        .waddr (waddr),
        .wdata (deq_item.value),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
        end
        if (take) begin
            res_valid_next = 1'b1;
            res_next       = '{status: ST_OK, value: '0, lane: '0};
            unique case (deq_item.op)
                OP_LOAD: begin
                    if (full) begin
                        res_next.status = ST_DROP;
                    end
                end
                OP_DROP: res_next.status = ST_DROP;
                OP_POP: begin
                    if (!any_valid) begin
                        res_next.status = ST_EMPTY;
                    end else begin
                        res_next.value = win_value;
                        res_next.lane  = IN_LANE_W'(win_lane);
                        if (!pop_last) begin
                            state_next = S_REFILL;
                        end
                    end
                end
                default: ;
            endcase
        end
        if (state_reg == S_REFILL) begin
            state_next = S_EXEC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_EXEC;
            res_valid_reg  <= 1'b0;
            head_valid_reg <= '0;
            for (int i = 0; i < LANES; i++) begin
                count_reg[i]   <= '0;
                wr_slot_reg[i] <= '0;
                rd_slot_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (do_clear) begin
                head_valid_reg <= '0;
                for (int i = 0; i < LANES; i++) begin
                    count_reg[i]   <= '0;
                    wr_slot_reg[i] <= '0;
                    rd_slot_reg[i] <= '0;
                end
            end
            if (do_load) begin
                count_reg[sel_lane]      <= sel_count + 1'b1;
                wr_slot_reg[sel_lane]    <= slot_inc(sel_wr);
                head_valid_reg[sel_lane] <= 1'b1;
            end
            if (do_pop) begin
                count_reg[sel_lane]   <= sel_count - 1'b1;
                rd_slot_reg[sel_lane] <= slot_inc(sel_rd);
                if (pop_last) begin
                    head_valid_reg[sel_lane] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (do_load && !head_valid_reg[sel_lane]) begin
            head_value_reg[sel_lane] <= deq_item.value;
        end
        if (do_pop) begin
            refill_lane_reg <= sel_lane;
        end
        if (state_reg == S_REFILL) begin
            head_value_reg[refill_lane_reg] <= rdata;
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            cnt_nz[i] = (count_reg[i] != '0);
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_refill_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_REFILL |=> state_reg == S_EXEC)
        else $error("refill lasted more than one cycle");

    a_head_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid_reg == cnt_nz)
        else $error("head valid bits disagree with lane counts");

    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        do_load |-> sel_count < CNT_W'(LANE_DEPTH))
        else $error("write into a full lane");

    a_pop_finds_head: assert property (@(posedge aclk) disable iff (!aresetn)
        take && deq_item.op == OP_POP && (|head_valid_reg)
        |=> res_valid_reg && res_reg.status == ST_OK)
        else $error("pop with a valid head did not report ok");
`endif
endmodule

FILE: rtl/kway_sorted_merge_core.sv
// Top level of the k-way sorted merge core.
//
// Merges up to eight ascending lanes of signed 32-bit values into one ascending
// stream. Each input transfer carries a command in s_tuser: load appends the value
// to the tail of the given lane (dropped with status 2 when the lane already holds
// LANE_DEPTH values or the lane index is out of range), pop returns the smallest
// head among the non-empty lanes with its lane index and advances that lane
// (lower lane wins ties, status 1 when all lanes are empty), clear empties every
// lane, and the unused command code does nothing. Every command yields exactly one
// result transfer. A front stage classifies commands into a two-entry queue and a
// back stage executes them against per-lane pointers and counts, a register per
// lane that holds its head value, and one lane storage RAM with a single write and
// a single registered read port. Load, clear, dropped loads, empty pops and pops
// that empty their lane finish in the execute state of the back stage; a pop that
// leaves data in its lane then passes through the refill state, which loads the
// lane's head register from the RAM read port while no new command is taken. A result
// register parts the output from the engine; while a result waits for m_tready the
// engine finishes any refill in progress and then holds, and the front queue keeps
// taking input transfers until both of its entries are occupied. Lane storage needs
// no clearing pass after reset: only entries that a load wrote are ever read back.
module kway_sorted_merge_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kwm_pkg::DATA_W-1:0]    s_tdata,   // lane [2:0], value [34:3], zero pad
    input  logic [kwm_pkg::CMD_W-1:0]     s_tuser,   // cmd [1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kwm_pkg::DATA_W-1:0]    m_tdata,   // out_value [31:0], out_lane [34:32], zero pad
    output logic [kwm_pkg::STATUS_W-1:0]  m_tuser    // status [1:0]
);
    import kwm_pkg::*;

    logic      deq_valid;
    logic      deq_ready;
    cmd_item_t deq_item;
    result_t   res;

    // Accept and classify input transfers
    kwm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_item  (deq_item)
    );

    // Execute commands and hold the result until the sink takes it
    kwm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .deq_valid (deq_valid),
        .deq_ready (deq_ready),
        .deq_item  (deq_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {{(DATA_W - VALUE_W - IN_LANE_W){1'b0}}, res.lane, res.value};
    assign m_tuser = res.status;
endmodule
